>>> design/rme_pkg.sv
// Package: shared constants, types and helper functions for the Euler angle pipeline.
`default_nettype none
package rme_pkg;

  // number of CORDIC micro-rotations (8..24)
  localparam int CORDIC_STAGES = 16;
  // CORDIC operand width in, Q2.14 plus a sign bit for negated entries
  localparam int OPW = 17;
  // CORDIC x/y datapath width (operand << 14 plus gain growth)
  localparam int CW = 36;
  // angle accumulator width, radians * 2^30
  localparam int ZW = 34;
  // 1/A gain compensation, Q30
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;

  typedef logic signed [OPW-1:0] op_t;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] ang_t;
  typedef logic signed [15:0] q13_t;

  // atan(2^-i) * 2^30, truncated
  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    case (i)
      0: r = 30'd843314856;
      1: r = 30'd497837829;
      2: r = 30'd263043836;
      3: r = 30'd133525158;
      4: r = 30'd67021686;
      5: r = 30'd33543515;
      6: r = 30'd16775850;
      7: r = 30'd8388437;
      8: r = 30'd4194282;
      9: r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Q30 angle to Q3.13 with round half up, clamped to +-pi
  function automatic q13_t angle_out(input ang_t z);
    logic signed [ZW:0] s;
    logic signed [ZW:0] a;
    q13_t r;
    s = {z[ZW-1], z} + (ZW+1)'(65536);
    a = s >>> 17;
    if (a > (ZW+1)'(PI_Q13)) r = PI_Q13;
    else if (a < -(ZW+1)'(PI_Q13)) r = -PI_Q13;
    else r = a[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/rme_cordic.sv
// Pipelined vectoring CORDIC: pre-rotation stage then one register per micro-rotation.
`default_nettype none
module rme_cordic (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire rme_pkg::op_t  opx,
  input  wire rme_pkg::op_t  opy,
  output rme_pkg::cw_t       mag,
  output rme_pkg::ang_t      ang
);
  import rme_pkg::*;

  cw_t  x_w [0:CORDIC_STAGES];
  cw_t  y_w [0:CORDIC_STAGES];
  ang_t z_w [0:CORDIC_STAGES];
  logic zf_w [0:CORDIC_STAGES];

  cw_t  xin, yin;
  cw_t  x0, y0;
  ang_t z0q;
  cw_t  x0q, y0q;
  logic zf0q;

  // scale operands into 2^-28 units
  assign xin = {{(CW-OPW-14){opx[OPW-1]}}, opx, 14'd0};
  assign yin = {{(CW-OPW-14){opy[OPW-1]}}, opy, 14'd0};

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zf0q <= (xin == '0) && (yin == '0);
      if (xin[CW-1] && !yin[CW-1]) begin
        x0q <= yin;
        y0q <= -xin;
        z0q <= HALF_PI_Q30;
      end else if (xin[CW-1]) begin
        x0q <= -yin;
        y0q <= xin;
        z0q <= -HALF_PI_Q30;
      end else begin
        x0q <= xin;
        y0q <= yin;
        z0q <= '0;
      end
    end
  end

  assign x0 = x0q;
  assign y0 = y0q;
  assign x_w[0] = x0;
  assign y_w[0] = y0;
  assign z_w[0] = z0q;
  assign zf_w[0] = zf0q;

  // micro-rotation stages
  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_it
    cw_t  xsh, ysh, xq, yq;
    ang_t zq, step;
    logic zfq;
    assign xsh = x_w[gi] >>> gi;
    assign ysh = y_w[gi] >>> gi;
    assign step = ang_t'({4'd0, atan_q30(gi)});
    always_ff @(posedge clk) begin
      if (en) begin
        zfq <= zf_w[gi];
        if (!y_w[gi][CW-1]) begin
          xq <= x_w[gi] + ysh;
          yq <= y_w[gi] - xsh;
          zq <= z_w[gi] + step;
        end else begin
          xq <= x_w[gi] - ysh;
          yq <= y_w[gi] + xsh;
          zq <= z_w[gi] - step;
        end
      end
    end
    assign x_w[gi+1] = xq;
    assign y_w[gi+1] = yq;
    assign z_w[gi+1] = zq;
    assign zf_w[gi+1] = zfq;
  end

  // zero vector gives zero magnitude and angle
  assign mag = zf_w[CORDIC_STAGES] ? '0 : x_w[CORDIC_STAGES];
  assign ang = zf_w[CORDIC_STAGES] ? '0 : z_w[CORDIC_STAGES];

endmodule
`default_nettype wire

>>> design/rotation_matrix_to_euler_top.sv
// Top level: rotation matrix to XYZ Euler angles, fully pipelined.
//
//  channel  | handshake                  | word
//  ---------+----------------------------+------------------------------------
//  input    | in_valid / in_stall        | m00 m10 m20 m21 m22 m12 m11
//  output   | out_valid / out_stall      | roll pitch yaw is_singular
//  config   | singular_limit_we          | singular_limit
//
// One word enters per cycle while in_stall is low; the pipeline depth is set by the
// two CORDIC pipelines in series (sy/yaw/roll first, pitch second).
// Synchronous reset clears all valid bits; the limit resets to 1.
// A stalled output word freezes the whole pipeline; in_stall follows it directly.
`default_nettype none
module rotation_matrix_to_euler_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         singular_limit_we,
  input  wire logic [14:0]  singular_limit,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic signed [15:0] m00,
  input  wire logic signed [15:0] m10,
  input  wire logic signed [15:0] m20,
  input  wire logic signed [15:0] m21,
  input  wire logic signed [15:0] m22,
  input  wire logic signed [15:0] m12,
  input  wire logic signed [15:0] m11,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [15:0] roll,
  output logic signed [15:0] pitch,
  output logic signed [15:0] yaw,
  output logic              is_singular
);
  import rme_pkg::*;

  localparam int LA = CORDIC_STAGES + 1;
  localparam int LT = LA + 2 + LA + 1;

  logic en;
  logic [14:0] limit;
  logic v [0:LT-1];

  cw_t  mag_a, mag_n, mag_s, mag_p;
  ang_t yaw_z, roll_nz, roll_sz, pitch_z;
  op_t  m20_d [0:LA-1];

  // stage M1 / M2 registers
  logic [62:0] prod;
  q13_t yaw1, rolln1, rolls1, yaw2, roll2;
  op_t  m20_1, negm20;
  logic [16:0] sy2;
  logic sing2;

  // side data across the pitch CORDIC
  q13_t roll_d [0:LA-1];
  q13_t yaw_d [0:LA-1];
  logic sing_d [0:LA-1];

  logic [63:0] sy_sum;
  logic [16:0] sy;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) limit <= 15'd1;
    else if (singular_limit_we) limit <= singular_limit;
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LT; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i < LT; i++) v[i] <= v[i-1];
    end
  end
  assign out_valid = v[LT-1];

  // first CORDIC bank: yaw/sy and both roll candidates
  rme_cordic u_cyaw (.clk(clk), .en(en), .opx(op_t'(m00)), .opy(op_t'(m10)),
                     .mag(mag_a), .ang(yaw_z));
  rme_cordic u_croll (.clk(clk), .en(en), .opx(op_t'(m22)), .opy(op_t'(m21)),
                      .mag(mag_n), .ang(roll_nz));
  rme_cordic u_crolls (.clk(clk), .en(en), .opx(op_t'(m11)), .opy(-op_t'(m12)),
                       .mag(mag_s), .ang(roll_sz));

  // m20 delay alongside the first bank
  always_ff @(posedge clk) begin
    if (en) begin
      m20_d[0] <= op_t'(m20);
      for (int i = 1; i < LA; i++) m20_d[i] <= m20_d[i-1];
    end
  end

  // M1: gain multiply, angles to Q3.13
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= mag_a[32:0] * INV_GAIN_Q30;
      yaw1   <= angle_out(yaw_z);
      rolln1 <= angle_out(roll_nz);
      rolls1 <= angle_out(roll_sz);
      m20_1  <= m20_d[LA-1];
    end
  end

  // M2: round sy, singular decision
  assign sy_sum = {1'b0, prod} + 64'(1) * (64'd1 << 43);
  assign sy = sy_sum[60:44];

  always_ff @(posedge clk) begin
    if (en) begin
      sy2    <= sy;
      sing2  <= sy < {2'd0, limit};
      negm20 <= -m20_1;
      if (sy < {2'd0, limit}) begin
        roll2 <= rolls1;
        yaw2  <= '0;
      end else begin
        roll2 <= rolln1;
        yaw2  <= yaw1;
      end
    end
  end

  // pitch CORDIC
  rme_cordic u_cpitch (.clk(clk), .en(en), .opx(op_t'(sy2)), .opy(negm20),
                       .mag(mag_p), .ang(pitch_z));

  always_ff @(posedge clk) begin
    if (en) begin
      roll_d[0] <= roll2;
      yaw_d[0]  <= yaw2;
      sing_d[0] <= sing2;
      for (int i = 1; i < LA; i++) begin
        roll_d[i] <= roll_d[i-1];
        yaw_d[i]  <= yaw_d[i-1];
        sing_d[i] <= sing_d[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      roll        <= roll_d[LA-1];
      yaw         <= yaw_d[LA-1];
      is_singular <= sing_d[LA-1];
      pitch       <= angle_out(pitch_z);
    end
  end

  logic unused_mag;
  assign unused_mag = ^{mag_n, mag_s, mag_p, mag_a[CW-1:33]};

endmodule
`default_nettype wire

>>> design/rme_checker.sv
// Checker on the top-level ports, bound to the top level.
`default_nettype none
module rme_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [15:0] roll,
  input wire logic signed [15:0] yaw,
  input wire logic is_singular
);

  // input backpressure follows a held output word
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall)) else $error("in_stall mismatch");

  // held word stays valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("word dropped under stall");

  // singular words carry zero yaw
  a_yaw: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_singular |-> yaw == 16'sd0) else $error("yaw not zero");

  // roll clamped to +-pi
  a_roll: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll <= 16'sd25736) && (roll >= -16'sd25736))
    else $error("roll out of range");

endmodule

bind rotation_matrix_to_euler_top rme_checker u_rme_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .roll(roll), .yaw(yaw), .is_singular(is_singular)
);
`default_nettype wire
